[rtl/core/epd_pkg.sv]
// shared types and constants for the escaped packet deframer
`timescale 1ns / 1ps

package epd_pkg;

  // widths fixed by the field definitions
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // default buffer depth in bytes
  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

  // marker reset values
  localparam logic [BYTE_W-1:0] START_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] STOP_RST   = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd16;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  // marker bytes handed to the controller
  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] stop_marker;
    logic [BYTE_W-1:0] escape_marker;
  } markers_t;

  // controller status seen by the top level
  typedef struct packed {
    logic             draining;
    logic [LEN_W-1:0] fill;
  } status_t;

endpackage

[rtl/core/epd_ram.sv]
// payload buffer: one write port, one registered read port
`timescale 1ns / 1ps

module epd_ram #(
  parameter int unsigned DEPTH = epd_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [epd_pkg::BYTE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [epd_pkg::BYTE_W-1:0] rdata_o
);

  logic [epd_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [epd_pkg::BYTE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/epd_ctrl.sv]
// byte classifier, packet state and readout sequencer
`timescale 1ns / 1ps

module epd_ctrl #(
  parameter int unsigned BUFFER_DEPTH = epd_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  epd_pkg::markers_t          markers_i,
  // input beat
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [epd_pkg::BYTE_W-1:0] in_byte_i,
  // buffer access
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [epd_pkg::BYTE_W-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [epd_pkg::BYTE_W-1:0] mem_rdata_i,
  // result beat
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [epd_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       out_last_o,
  output logic                       out_empty_o,
  output logic [epd_pkg::LEN_W-1:0]  out_len_o,
  output epd_pkg::status_t           status_o
);

  localparam logic [epd_pkg::LEN_W-1:0] DepthCnt = epd_pkg::LEN_W'(BUFFER_DEPTH);

  epd_pkg::state_e state_q, state_d;
  logic in_pkt_q, in_pkt_d;
  logic esc_q, esc_d;
  logic [epd_pkg::LEN_W-1:0] fill_q, fill_d;
  logic [epd_pkg::LEN_W-1:0] len_q, len_d;
  logic [epd_pkg::LEN_W-1:0] rd_idx_q, rd_idx_d;
  logic rd_pend_q, rd_pend_d;
  logic rd_last_q, rd_last_d;

  logic out_valid_q, out_valid_d;
  logic [epd_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic out_last_q, out_last_d;
  logic out_empty_q, out_empty_d;
  logic [epd_pkg::LEN_W-1:0] out_len_q, out_len_d;

  logic accept;
  logic out_free;
  logic [epd_pkg::BYTE_W-1:0] plain_byte;

  assign in_ready_o = (state_q == epd_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign plain_byte = esc_q ? (in_byte_i ^ markers_i.escape_marker) : in_byte_i;

  // next state, buffer access and result loading
  always_comb begin
    state_d     = state_q;
    in_pkt_d    = in_pkt_q;
    esc_d       = esc_q;
    fill_d      = fill_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = 1'b0;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_len_d   = out_len_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;

    unique case (state_q)
      epd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_byte_i == markers_i.escape_marker) begin
            esc_d = 1'b1;
          end else if (in_byte_i == markers_i.start_marker) begin
            in_pkt_d = 1'b1;
            esc_d    = 1'b0;
            fill_d   = '0;
          end else if (in_byte_i == markers_i.stop_marker) begin
            if (in_pkt_q) begin
              len_d    = fill_q;
              rd_idx_d = '0;
              state_d  = epd_pkg::ST_DRAIN;
            end
            in_pkt_d = 1'b0;
            esc_d    = 1'b0;
          end else begin
            esc_d = 1'b0;
            if (in_pkt_q) begin
              if (fill_q == DepthCnt) begin
                // packet too long, drop it
                in_pkt_d = 1'b0;
              end else begin
                mem_we_o = 1'b1;
                fill_d   = fill_q + 1'b1;
              end
            end
          end
        end
      end
      epd_pkg::ST_DRAIN: begin
        if (len_q == '0) begin
          // empty packet gives a single marked beat
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
            out_len_d   = '0;
            state_d     = epd_pkg::ST_IDLE;
          end
        end else if (rd_pend_q) begin
          // read data lands in the output register
          out_valid_d = 1'b1;
          out_byte_d  = mem_rdata_i;
          out_last_d  = rd_last_q;
          out_empty_d = 1'b0;
          out_len_d   = len_q;
          if (rd_last_q) begin
            state_d = epd_pkg::ST_IDLE;
          end
        end else if (out_free && (rd_idx_q != len_q)) begin
          mem_re_o  = 1'b1;
          rd_pend_d = 1'b1;
          rd_last_d = ((rd_idx_q + 1'b1) == len_q);
          rd_idx_d  = rd_idx_q + 1'b1;
        end
      end
      default: begin
        state_d = epd_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= epd_pkg::ST_IDLE;
      in_pkt_q    <= 1'b0;
      esc_q       <= 1'b0;
      fill_q      <= '0;
      len_q       <= '0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_pkt_q    <= in_pkt_d;
      esc_q       <= esc_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_len_q   <= out_len_d;
  end

  assign mem_waddr_o = fill_q[AW-1:0];
  assign mem_wdata_o = plain_byte;
  assign mem_raddr_o = rd_idx_q[AW-1:0];

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;
  assign out_len_o   = out_len_q;

  assign status_o.draining = (state_q == epd_pkg::ST_DRAIN);
  assign status_o.fill     = fill_q;

endmodule

[rtl/core/escaped_packet_deframer.sv]
// top level of the escaped packet deframer
`timescale 1ns / 1ps

// Recovers byte-stuffed packets from a raw byte stream: an escape byte makes
// the next byte XOR with the escape value, a start byte opens a packet, a stop
// byte closes it and plays its payload out in order with tlast on the final
// beat; an empty packet gives one beat with tuser set. Packets longer than
// BUFFER_DEPTH bytes are dropped. While no packet is being played out, one
// input beat is taken every cycle. A stop that closes a packet then holds the
// input until the packet has been played out, plus any output stall: the
// buffer has a single registered read port feeding a single output register,
// so each payload byte is read and then loaded before the next read is issued.
// Marker registers should be written while idle.
module escaped_packet_deframer #(
  parameter int unsigned BUFFER_DEPTH = epd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // marker register writes
  input  logic                          cfg_we_i,
  input  logic [epd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [epd_pkg::BYTE_W-1:0]    cfg_wdata_i,
  // received byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  // recovered payload stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [7:0] out_byte, [14:8] packet_length
  output logic                          m_axis_tlast,   // is_last
  output logic                          m_axis_tuser    // is_empty
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  epd_pkg::markers_t markers_q, markers_d;
  epd_pkg::status_t  status;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [epd_pkg::BYTE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [epd_pkg::BYTE_W-1:0] mem_rdata;

  logic [epd_pkg::BYTE_W-1:0] out_byte;
  logic [epd_pkg::LEN_W-1:0]  out_len;

  // marker register decode
  always_comb begin
    markers_d = markers_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        epd_pkg::CFG_START:  markers_d.start_marker  = cfg_wdata_i;
        epd_pkg::CFG_STOP:   markers_d.stop_marker   = cfg_wdata_i;
        epd_pkg::CFG_ESCAPE: markers_d.escape_marker = cfg_wdata_i;
        default:             markers_d = markers_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q.start_marker  <= epd_pkg::START_RST;
      markers_q.stop_marker   <= epd_pkg::STOP_RST;
      markers_q.escape_marker <= epd_pkg::ESCAPE_RST;
    end else begin
      markers_q <= markers_d;
    end
  end

  epd_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .markers_i   (markers_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_last_o  (m_axis_tlast),
    .out_empty_o (m_axis_tuser),
    .out_len_o   (out_len),
    .status_o    (status)
  );

  epd_ram #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {1'b0, out_len, out_byte};

  // fill level never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fill <= epd_pkg::LEN_W'(BUFFER_DEPTH))
    else $error("fill level beyond buffer depth");

  // input is held off while a packet plays out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.draining |-> !s_axis_tready)
    else $error("input taken during readout");

  // an empty-packet beat is the last one and carries zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (out_len == '0)))
    else $error("malformed empty packet beat");

  // a payload beat carries a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (out_len != '0))
    else $error("payload beat with zero length");

endmodule
